// File: rtl/gdfs_pkg.sv
// Shared types, codes and defaults for the adjacency-matrix depth-first search block.
package gdfs_pkg;

  // Width of every vertex number field
  localparam int VW = 5;

  // Default sizing handed to the top level
  localparam int MAX_VERTICES_DEF = 16;
  localparam int STACK_DEPTH_DEF  = 256;

  // Vertex count after reset
  localparam logic [VW-1:0] VCOUNT_RESET = 5'd16;

  // Command codes
  localparam logic CMD_EDGE     = 1'b0;
  localparam logic CMD_TRAVERSE = 1'b1;

  // One input item
  typedef struct packed {
    logic          cmd;
    logic [VW-1:0] first_vertex;
    logic [VW-1:0] second_vertex;
  } dfs_in_t;

  // One result item
  typedef struct packed {
    logic [VW-1:0] vertex;
    logic          last;
    logic          error;
  } dfs_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic row_rd_a;
    logic row_wr_a;
    logic row_rd_b;
    logic row_wr_b;
    logic emit_err;
    logic init;
    logic pop;
    logic finish;
    logic check;
    logic scan;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_trav;
    logic edge_ok;
    logic start_ok;
    logic sp_empty;
    logic v_new;
    logic scan_last;
  } dp_status_t;

endpackage

// File: rtl/gdfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gdfs_ctrl.sv
// Controller state machine sequencing edge updates and the depth-first traversal.
module gdfs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  gdfs_pkg::dp_status_t   status_i,
  output gdfs_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_E_RDA,
    S_E_WRA,
    S_E_RDB,
    S_E_WRB,
    S_T_INIT,
    S_T_POP,
    S_T_CHK,
    S_T_SCAN
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (status_i.is_trav) begin
          state_d = status_i.start_ok ? S_T_INIT : S_IDLE;
        end else begin
          state_d = status_i.edge_ok ? S_E_RDA : S_IDLE;
        end
      end
      S_E_RDA:  state_d = S_E_WRA;
      S_E_WRA:  state_d = S_E_RDB;
      S_E_RDB:  state_d = S_E_WRB;
      S_E_WRB:  state_d = S_IDLE;
      S_T_INIT: state_d = S_T_POP;
      S_T_POP: begin
        state_d = status_i.sp_empty ? S_IDLE : S_T_CHK;
      end
      S_T_CHK: begin
        state_d = status_i.v_new ? S_T_SCAN : S_T_POP;
      end
      S_T_SCAN: begin
        if (status_i.scan_last) state_d = S_T_POP;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode commands for the datapath
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && start;
    cmd_o.row_rd_a = (state_q == S_E_RDA);
    cmd_o.row_wr_a = (state_q == S_E_WRA);
    cmd_o.row_rd_b = (state_q == S_E_RDB);
    cmd_o.row_wr_b = (state_q == S_E_WRB);
    cmd_o.emit_err = (state_q == S_DECODE) && status_i.is_trav && !status_i.start_ok;
    cmd_o.init     = (state_q == S_T_INIT);
    cmd_o.pop      = (state_q == S_T_POP) && !status_i.sp_empty;
    cmd_o.finish   = (state_q == S_T_POP) && status_i.sp_empty;
    cmd_o.check    = (state_q == S_T_CHK);
    cmd_o.scan     = (state_q == S_T_SCAN);
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/gdfs_datapath.sv
// Datapath: adjacency rows, vertex stack, visited marks, scan counter and result register.
module gdfs_datapath #(
  parameter int MAX_VERTICES = gdfs_pkg::MAX_VERTICES_DEF,
  parameter int STACK_DEPTH  = gdfs_pkg::STACK_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gdfs_pkg::dfs_in_t                in_i,
  input  logic                             cfg_we_i,
  input  logic [gdfs_pkg::VW-1:0]          cfg_wdata_i,
  input  gdfs_pkg::ctrl_cmd_t              cmd_i,
  output gdfs_pkg::dp_status_t             status_o,
  output logic                             res_valid_o,
  output gdfs_pkg::dfs_out_t               res_o
);

  localparam int VW    = gdfs_pkg::VW;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  // Largest vertex number a field can carry and the matrix can hold
  localparam int VMAX  = (MAX_VERTICES > (2 ** VW) - 1) ? (2 ** VW) - 1 : MAX_VERTICES;

  // Vertex number to row and bit index
  function automatic logic [IDX_W-1:0] to_idx(input logic [VW-1:0] v);
    logic [VW-1:0] d;
    d = v - VW'(1);
    return IDX_W'(d);
  endfunction

  // Item and configuration registers
  logic                      cmd_q;
  logic [VW-1:0]             a_q, b_q;
  logic [VW-1:0]             vcount_q;
  logic [VW-1:0]             n_eff;

  // Traversal state
  logic [MAX_VERTICES-1:0]   visited_q;
  logic [SP_W-1:0]           sp_q;
  logic [VW-1:0]             i_q;
  logic [VW-1:0]             pend_q;
  logic                      pend_vld_q;

  // Row validity, cleared at reset, so unwritten rows read as no edges
  logic [MAX_VERTICES-1:0]   row_vld_q;
  logic                      rd_vld_q;

  // Result register
  gdfs_pkg::dfs_out_t        res_q;
  logic                      res_vld_q;

  // RAM ports
  logic                      row_we, row_re;
  logic [IDX_W-1:0]          row_waddr, row_raddr;
  logic [MAX_VERTICES-1:0]   row_wdata, row_rdata, row_data;
  logic                      stk_we, stk_re;
  logic [SA_W-1:0]           stk_waddr, stk_raddr;
  logic [VW-1:0]             stk_wdata, stk_rdata;

  logic [IDX_W-1:0]          a_idx, b_idx, v_idx, i_idx;
  logic                      stk_full, v_new, push_ok;

  // Clamp the vertex count to what the matrix holds
  assign n_eff = (vcount_q > VW'(VMAX)) ? VW'(VMAX) : vcount_q;

  assign a_idx = to_idx(a_q);
  assign b_idx = to_idx(b_q);
  assign v_idx = to_idx(stk_rdata);
  assign i_idx = to_idx(i_q);

  assign row_data = rd_vld_q ? row_rdata : '0;
  assign stk_full = (sp_q == SP_W'(STACK_DEPTH));
  assign v_new    = (stk_rdata != '0) && (stk_rdata <= n_eff) && !visited_q[v_idx];
  assign push_ok  = cmd_i.scan && row_data[i_idx] && !visited_q[i_idx] && !stk_full;

  // Adjacency row port steering
  always_comb begin
    row_re    = cmd_i.row_rd_a || cmd_i.row_rd_b || (cmd_i.check && v_new);
    row_raddr = cmd_i.row_rd_b ? b_idx : (cmd_i.check ? v_idx : a_idx);
    row_we    = cmd_i.row_wr_a || cmd_i.row_wr_b;
    row_waddr = cmd_i.row_wr_b ? b_idx : a_idx;
    row_wdata = row_data |
                ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << (cmd_i.row_wr_b ? a_idx : b_idx));
  end

  // Stack port steering
  always_comb begin
    stk_we    = cmd_i.init || push_ok;
    stk_waddr = cmd_i.init ? '0 : sp_q[SA_W-1:0];
    stk_wdata = cmd_i.init ? a_q : i_q;
    stk_re    = cmd_i.pop;
    stk_raddr = SA_W'(sp_q - SP_W'(1));
  end

  // Status toward the controller
  always_comb begin
    status_o.is_trav   = (cmd_q == gdfs_pkg::CMD_TRAVERSE);
    status_o.edge_ok   = (a_q != '0) && (a_q <= n_eff) && (b_q != '0) && (b_q <= n_eff);
    status_o.start_ok  = (a_q != '0) && (a_q <= n_eff);
    status_o.sp_empty  = (sp_q == '0);
    status_o.v_new     = v_new;
    status_o.scan_last = (i_q == VW'(1));
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= gdfs_pkg::VCOUNT_RESET;
      visited_q  <= '0;
      sp_q       <= '0;
      pend_vld_q <= 1'b0;
      row_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      // Track written rows and qualify read data
      if (row_we) begin
        row_vld_q[row_waddr] <= 1'b1;
      end
      if (row_re) begin
        rd_vld_q <= row_vld_q[row_raddr];
      end
      // Strobe one transfer: a bad start, a released vertex or the last one
      res_vld_q <= cmd_i.emit_err || (cmd_i.check && v_new && pend_vld_q) ||
                   (cmd_i.finish && pend_vld_q);
      // Fresh traversal with the start vertex pushed
      if (cmd_i.init) begin
        visited_q  <= '0;
        sp_q       <= SP_W'(1);
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.pop) begin
        sp_q <= sp_q - SP_W'(1);
      end
      // Newly visited vertex: mark it and hold it back
      if (cmd_i.check && v_new) begin
        visited_q[v_idx] <= 1'b1;
        pend_vld_q       <= 1'b1;
      end
      if (push_ok) begin
        sp_q <= sp_q + SP_W'(1);
      end
      // Stack drained: the held vertex is the last one
      if (cmd_i.finish) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_i.cmd;
      a_q   <= in_i.first_vertex;
      b_q   <= in_i.second_vertex;
    end
    if (cmd_i.check && v_new) begin
      i_q    <= n_eff;
      pend_q <= stk_rdata;
    end else if (cmd_i.scan) begin
      i_q <= i_q - VW'(1);
    end
    if (cmd_i.emit_err) begin
      res_q.vertex <= '0;
      res_q.last   <= 1'b1;
      res_q.error  <= 1'b1;
    end else if (cmd_i.check) begin
      res_q.vertex <= pend_q;
      res_q.last   <= 1'b0;
      res_q.error  <= 1'b0;
    end else if (cmd_i.finish) begin
      res_q.vertex <= pend_q;
      res_q.last   <= 1'b1;
      res_q.error  <= 1'b0;
    end
  end

  gdfs_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  gdfs_ram #(
    .WIDTH (VW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

// File: rtl/graph_dfs_adjacency_matrix.sv
// Top level of the adjacency-matrix depth-first search block.
//
// Usage: drive in_i and raise start; the item transfers on a clock edge with start high
// and busy low. An edge item (cmd 0) with both vertices in range sets both symmetric
// matrix bits; no edge item gives a result. A traverse item (cmd 1) runs a
// stack-based depth-first search and shows each newly visited vertex on res_o for one
// cycle with res_valid_o, in visit order; the last one carries last. A bad start vertex
// gives one result with error and last set. Traversal time is dominated by the
// one-bit-per-cycle scan of each visited vertex's matrix row over the n active vertices.
// Every result except the last appears while the search still runs; the final one
// shows once busy is low again. The receiver cannot stall; results are never held.
// The user must write the vertex count register (cfg_we_i, cfg_wdata_i) only while idle; the block does not check.
// Reset: vertex count returns to 16, the matrix reads as no edges (row valid flags
// clear at once, no clearing pass), the stack is empty and busy is low.
module graph_dfs_adjacency_matrix #(
  parameter int MAX_VERTICES = gdfs_pkg::MAX_VERTICES_DEF,
  parameter int STACK_DEPTH  = gdfs_pkg::STACK_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  gdfs_pkg::dfs_in_t       in_i,
  output logic                    busy,
  input  logic                    cfg_we_i,
  input  logic [gdfs_pkg::VW-1:0] cfg_wdata_i,
  output logic                    res_valid_o,
  output gdfs_pkg::dfs_out_t      res_o
);

  gdfs_pkg::ctrl_cmd_t  cmd;
  gdfs_pkg::dp_status_t status;

  gdfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  gdfs_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // An accepted item always makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after an input transfer");

  // The closing transfer of an item appears only once the block is idle
  a_last_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("last result while still busy");

  // An error result is always the only, hence last, result
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.error |-> res_o.last && (res_o.vertex == '0))
    else $error("malformed error result");

  // A visited vertex is never numbered zero
  a_vertex_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.error |-> res_o.vertex != '0)
    else $error("zero vertex in a traversal result");

endmodule

// File: dv/tb_graph_dfs_adjacency_matrix.sv
// Self-checking testbench for the adjacency-matrix depth-first search block.
module tb_graph_dfs_adjacency_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW          = gdfs_pkg::VW;
  localparam int NV          = gdfs_pkg::MAX_VERTICES_DEF;
  localparam int SD          = gdfs_pkg::STACK_DEPTH_DEF;
  localparam int SETTLE      = 8;
  localparam int DRAIN_TAIL  = 40;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SEG_ITEMS   = 63;

  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_CFG,
    ACT_DRAIN
  } act_kind_e;

  // One step of the stimulus plan: an item, a register write or a wait for drain
  typedef struct packed {
    act_kind_e          kind;
    gdfs_pkg::dfs_in_t  item;
    logic [VW-1:0]      value;
    int                 gap_pct;
  } plan_step_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  gdfs_pkg::dfs_in_t  item_in   = '0;
  logic               cfg_we    = 1'b0;
  logic [VW-1:0]      cfg_wdata = '0;
  logic               busy;
  logic               res_valid;
  gdfs_pkg::dfs_out_t res;

  plan_step_t         plan [$];
  gdfs_pkg::dfs_out_t visits_due [$];

  // Shadow of the block state
  logic [NV-1:0] adj_rows [NV] = '{default: '0};
  logic [VW-1:0] vcount = gdfs_pkg::VCOUNT_RESET;

  logic          took        = 1'b0;
  int            idle_run    = 0;
  int            cycle_count = 0;
  int            fail_count  = 0;
  int            items_taken = 0;
  int            results_checked = 0;
  int            traversals_run  = 0;
  int            error_results   = 0;
  int            cfg_writes      = 0;

  graph_dfs_adjacency_matrix uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .in_i        (item_in),
    .busy        (busy),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always #5 clk = ~clk;

  // Apply one item to the shadow matrix and queue the visit order it yields
  function automatic void predict_dfs(gdfs_pkg::dfs_in_t it);
    int                 n;
    int                 a;
    int                 b;
    int                 v;
    int                 sp;
    logic [NV-1:0]      seen;
    logic [VW-1:0]      stk [SD];
    gdfs_pkg::dfs_out_t held;
    logic               have_held;
    n = (vcount > NV) ? NV : int'(vcount);
    a = it.first_vertex;
    b = it.second_vertex;
    if (it.cmd == gdfs_pkg::CMD_EDGE) begin
      if (a >= 1 && a <= n && b >= 1 && b <= n) begin
        adj_rows[a-1][b-1] = 1'b1;
        adj_rows[b-1][a-1] = 1'b1;
      end
      return;
    end
    traversals_run++;
    if (a < 1 || a > n) begin
      held.vertex = '0;
      held.last   = 1'b1;
      held.error  = 1'b1;
      visits_due.push_back(held);
      error_results++;
      return;
    end
    seen      = '0;
    stk[0]    = a[VW-1:0];
    sp        = 1;
    have_held = 1'b0;
    held      = '0;
    while (sp > 0) begin
      sp--;
      v = stk[sp];
      if (v >= 1 && v <= n && !seen[v-1]) begin
        seen[v-1] = 1'b1;
        // hold each visit back one step so the final one can take the last flag
        if (have_held) visits_due.push_back(held);
        held.vertex = v[VW-1:0];
        held.last   = 1'b0;
        held.error  = 1'b0;
        have_held   = 1'b1;
        for (int i = n; i >= 1; i--) begin
          if (adj_rows[v-1][i-1] && !seen[i-1] && sp < SD) begin
            stk[sp] = i[VW-1:0];
            sp++;
          end
        end
      end
    end
    held.last = 1'b1;
    visits_due.push_back(held);
  endfunction

  // Monitor: check results, track register writes and item transfers
  always @(posedge clk) begin : monitor
    gdfs_pkg::dfs_out_t want;
    if (rst_n) begin
      if ($isunknown(res_valid)) begin
        $error("res_valid unknown");
        fail_count++;
      end else if (res_valid) begin
        if (visits_due.size() == 0) begin
          $error("unexpected result: vertex %0d last %0b error %0b",
                 res.vertex, res.last, res.error);
          fail_count++;
        end else begin
          want = visits_due.pop_front();
          results_checked++;
          if (res.vertex !== want.vertex) begin
            $error("vertex: expected %0d, actual %0d", want.vertex, res.vertex);
            fail_count++;
          end
          if (res.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, res.last);
            fail_count++;
          end
          if (res.error !== want.error) begin
            $error("error: expected %0b, actual %0b", want.error, res.error);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        vcount = cfg_wdata;
        cfg_writes++;
      end
      if (start && !busy) begin
        predict_dfs(item_in);
        items_taken++;
      end
      took <= start && !busy;
      if (busy || start || res_valid || visits_due.size() != 0) idle_run <= 0;
      else idle_run <= idle_run + 1;
    end
  end

  // Driver: present planned steps at the falling edge
  always @(negedge clk) begin : driver
    logic              nxt_start;
    gdfs_pkg::dfs_in_t nxt_in;
    logic              nxt_we;
    logic [VW-1:0]     nxt_wdata;
    plan_step_t        step;
    if (rst_n) begin
      nxt_start = start;
      nxt_in    = item_in;
      nxt_we    = 1'b0;
      nxt_wdata = cfg_wdata;
      // drop the item once its transfer has happened
      if (start && took) nxt_start = 1'b0;
      if (!nxt_start && plan.size() != 0) begin
        step = plan[0];
        case (step.kind)
          ACT_ITEM: begin
            if ($urandom_range(99) >= step.gap_pct) begin
              nxt_start = 1'b1;
              nxt_in    = step.item;
              void'(plan.pop_front());
            end
          end
          ACT_CFG: begin
            if (idle_run >= SETTLE) begin
              nxt_we    = 1'b1;
              nxt_wdata = step.value;
              void'(plan.pop_front());
            end
          end
          default: begin
            if (idle_run >= SETTLE) void'(plan.pop_front());
          end
        endcase
      end
      start     <= nxt_start;
      item_in   <= nxt_in;
      cfg_we    <= nxt_we;
      cfg_wdata <= nxt_wdata;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_item(logic cmd, int a, int b, int gap);
    plan_step_t s;
    s                    = '0;
    s.kind               = ACT_ITEM;
    s.item.cmd           = cmd;
    s.item.first_vertex  = a[VW-1:0];
    s.item.second_vertex = b[VW-1:0];
    s.gap_pct            = gap;
    plan.push_back(s);
  endtask

  task automatic add_cfg(int value);
    plan_step_t s;
    s       = '0;
    s.kind  = ACT_CFG;
    s.value = value[VW-1:0];
    plan.push_back(s);
  endtask

  initial begin : stimulus
    int   seg_vc  [6] = '{6, 16, 3, 20, 11, 16};
    int   seg_gap [6] = '{10, 10, 84, 84, 0, 0};
    int   n_eff;
    int   counted;
    int   a;
    int   b;
    logic cmd;
    plan_step_t hold;

    // Directed: empty graph, bad starts, edge corner cases at the reset count
    add_item(gdfs_pkg::CMD_TRAVERSE, 1, 0, 0);
    add_item(gdfs_pkg::CMD_TRAVERSE, 0, 31, 0);
    add_item(gdfs_pkg::CMD_TRAVERSE, 17, 0, 0);
    add_item(gdfs_pkg::CMD_TRAVERSE, 31, 31, 0);
    add_item(gdfs_pkg::CMD_EDGE, 1, 16, 0);
    add_item(gdfs_pkg::CMD_EDGE, 16, 15, 0);
    add_item(gdfs_pkg::CMD_EDGE, 3, 3, 0);
    add_item(gdfs_pkg::CMD_EDGE, 0, 2, 0);
    add_item(gdfs_pkg::CMD_EDGE, 2, 17, 0);
    add_item(gdfs_pkg::CMD_EDGE, 31, 31, 0);
    add_item(gdfs_pkg::CMD_EDGE, 1, 2, 0);
    add_item(gdfs_pkg::CMD_EDGE, 2, 3, 0);
    add_item(gdfs_pkg::CMD_TRAVERSE, 1, 0, 0);
    add_item(gdfs_pkg::CMD_TRAVERSE, 16, 0, 0);
    add_item(gdfs_pkg::CMD_TRAVERSE, 3, 0, 0);
    // Single vertex in use
    add_cfg(1);
    add_item(gdfs_pkg::CMD_TRAVERSE, 1, 0, 0);
    add_item(gdfs_pkg::CMD_TRAVERSE, 2, 0, 0);
    add_item(gdfs_pkg::CMD_EDGE, 1, 1, 0);
    add_item(gdfs_pkg::CMD_EDGE, 1, 2, 0);
    // No vertex in use
    add_cfg(0);
    add_item(gdfs_pkg::CMD_TRAVERSE, 1, 0, 0);
    add_item(gdfs_pkg::CMD_EDGE, 1, 1, 0);
    // Count above the maximum acts as the maximum
    add_cfg(31);
    add_item(gdfs_pkg::CMD_TRAVERSE, 16, 0, 0);
    add_item(gdfs_pkg::CMD_EDGE, 4, 16, 0);
    add_item(gdfs_pkg::CMD_TRAVERSE, 17, 0, 0);
    add_item(gdfs_pkg::CMD_TRAVERSE, 4, 0, 0);

    // Random segments, each with its own vertex count and sender gap rate
    for (int seg = 0; seg < 6; seg++) begin
      add_cfg(seg_vc[seg]);
      n_eff   = (seg_vc[seg] > NV) ? NV : seg_vc[seg];
      counted = 0;
      while (counted < SEG_ITEMS) begin
        cmd = ($urandom_range(99) < 30) ? gdfs_pkg::CMD_EDGE : gdfs_pkg::CMD_TRAVERSE;
        a   = ($urandom_range(9) == 0) ? int'($urandom_range(31))
                                       : int'($urandom_range(n_eff, 1));
        b   = ($urandom_range(9) == 0) ? int'($urandom_range(31))
                                       : int'($urandom_range(n_eff, 1));
        add_item(cmd, a, b, seg_gap[seg]);
        if (cmd == gdfs_pkg::CMD_TRAVERSE || (a >= 1 && a <= n_eff && b >= 1 && b <= n_eff))
          counted++;
        // pause the sender until all pending results are in
        if (seg == 1 && counted == SEG_ITEMS / 2 && cmd == gdfs_pkg::CMD_TRAVERSE) begin
          hold      = '0;
          hold.kind = ACT_DRAIN;
          plan.push_back(hold);
        end
      end
    end

    // Reset once, release at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for all stimulus and results, then a quiet tail
    do @(posedge clk);
    while (plan.size() != 0 || start || busy || visits_due.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Ran %0d items (%0d traversals, %0d bad starts) over %0d vertex-count writes,",
             items_taken, traversals_run, error_results, cfg_writes);
    $display("checked %0d visit results in %0d cycles.", results_checked, cycle_count);
    if (fail_count == 0 && visits_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
